/* rtl/pbhcp_pkg.sv */
// ----------------------------------------------------------------------------
// pbhcp_pkg: shared types and constants for the host command parser
// Parse phases, submessage kinds, event kinds, csr indices and the event structs.
// ----------------------------------------------------------------------------
package pbhcp_pkg;

   typedef enum logic [3:0] {
      PH_TOP_KEY  = 4'd0,
      PH_TOP_VAL  = 4'd1,
      PH_TOP_LEN  = 4'd2,
      PH_SKIP     = 4'd3,
      PH_SUB_KEY  = 4'd4,
      PH_SUB_VAL  = 4'd5,
      PH_SUB_LEN  = 4'd6,
      PH_SUB_DATA = 4'd7,
      PH_ERROR    = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      SK_NONE   = 3'd0,
      SK_REBOOT = 3'd1,
      SK_BEGIN  = 3'd2,
      SK_CHUNK  = 3'd3,
      SK_NFC    = 3'd4
   } sub_kind_type;

   localparam logic [4:0] EV_NONCE       = 5'd0;
   localparam logic [4:0] EV_NODE_ID     = 5'd1;
   localparam logic [4:0] EV_ADDRESSED   = 5'd2;
   localparam logic [4:0] EV_REBOOT_UPD  = 5'd3;
   localparam logic [4:0] EV_REBOOT_ROM  = 5'd4;
   localparam logic [4:0] EV_FLASH_SIZE  = 5'd5;
   localparam logic [4:0] EV_UART_INV    = 5'd9;
   localparam logic [4:0] EV_CHUNK_OFS   = 5'd10;
   localparam logic [4:0] EV_CHUNK_LEN   = 5'd11;
   localparam logic [4:0] EV_CHUNK_BYTE  = 5'd12;
   localparam logic [4:0] EV_NFC_CMD     = 5'd13;
   localparam logic [4:0] EV_NFC_LEN     = 5'd14;
   localparam logic [4:0] EV_NFC_BYTE    = 5'd15;
   localparam logic [4:0] EV_END         = 5'd16;

   localparam logic CSR_NFC_LOW  = 1'b0;
   localparam logic CSR_NFC_HIGH = 1'b1;

   typedef struct packed {
      logic [4:0]  kind;
      logic [31:0] value;
      logic [3:0]  op;
      logic        ok;
      logic        eom;
   } event_type;

   typedef struct packed {
      logic      ev_valid;
      event_type ev;
      logic      end_valid;
      event_type end_ev;
   } step_out_type;

endpackage

/* rtl/pbhcp_core.sv */
// ----------------------------------------------------------------------------
// pbhcp_core: parser state and one-byte step logic
// Holds the parse state; each accepted byte advances it and yields up to
// one data event and one end verdict.
// ----------------------------------------------------------------------------
module pbhcp_core #(
   parameter int CHUNK_MAX       = 256,
   parameter int NFC_PAYLOAD_MAX = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic [7:0]               in_byte,
   input  logic                     msg_last,
   input  logic [31:0]              nfc_low,
   input  logic [31:0]              nfc_high,
   output pbhcp_pkg::step_out_type  result
);
   import pbhcp_pkg::*;

   localparam logic [31:0] CHUNK_LIM = 32'(CHUNK_MAX);
   localparam logic [31:0] NFC_LIM   = 32'(NFC_PAYLOAD_MAX);

   phase_type    phase_ff, phase_in;
   logic         insub_ff, insub_in;
   sub_kind_type sk_ff, sk_in;
   logic [31:0]  acc_ff, acc_in;
   logic [2:0]   nb_ff, nb_in;
   logic [28:0]  fld_ff, fld_in;
   logic [31:0]  subrem_ff, subrem_in;
   logic [31:0]  skip_ff, skip_in;
   logic [3:0]   op_ff, op_in;
   logic [31:0]  nfc_ff, nfc_in;
   logic         err_ff, err_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_TOP_KEY;
         insub_ff  <= 1'b0;
         sk_ff     <= SK_NONE;
         acc_ff    <= '0;
         nb_ff     <= '0;
         fld_ff    <= '0;
         subrem_ff <= '0;
         skip_ff   <= '0;
         op_ff     <= '0;
         nfc_ff    <= '0;
         err_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         insub_ff  <= insub_in;
         sk_ff     <= sk_in;
         acc_ff    <= acc_in;
         nb_ff     <= nb_in;
         fld_ff    <= fld_in;
         subrem_ff <= subrem_in;
         skip_ff   <= skip_in;
         op_ff     <= op_in;
         nfc_ff    <= nfc_in;
         err_ff    <= err_in;
      end
   end

   // one byte step
   always_comb begin
      logic [31:0] v;
      logic [31:0] sh;
      logic        data;
      logic        fail;
      logic        close;
      logic        ok;
      phase_type   ph;
      phase_in  = phase_ff;
      insub_in  = insub_ff;
      sk_in     = sk_ff;
      acc_in    = acc_ff;
      nb_in     = nb_ff;
      fld_in    = fld_ff;
      subrem_in = subrem_ff;
      skip_in   = skip_ff;
      op_in     = op_ff;
      nfc_in    = nfc_ff;
      err_in    = err_ff;
      result    = '0;
      fail      = 1'b0;
      close     = 1'b0;
      data      = 1'b0;
      ok        = 1'b0;
      v         = '0;
      sh        = '0;
      ph        = phase_ff;

      if (phase_ff != PH_ERROR) begin
         if (insub_ff && subrem_ff != 32'd0) subrem_in = subrem_ff - 32'd1;
         if (phase_ff == PH_SKIP || phase_ff == PH_SUB_DATA) begin
            if (phase_ff == PH_SUB_DATA) begin
               result.ev_valid = 1'b1;
               result.ev.kind  = (sk_ff == SK_CHUNK) ? EV_CHUNK_BYTE : EV_NFC_BYTE;
               result.ev.value = {24'd0, in_byte};
            end
            skip_in = skip_ff - 32'd1;
            if (skip_in == 32'd0) phase_in = insub_ff ? PH_SUB_KEY : PH_TOP_KEY;
         end else begin
            // varint accumulate
            case (nb_ff)
               3'd0:    sh = {25'd0, in_byte[6:0]};
               3'd1:    sh = {18'd0, in_byte[6:0], 7'd0};
               3'd2:    sh = {11'd0, in_byte[6:0], 14'd0};
               3'd3:    sh = {4'd0, in_byte[6:0], 21'd0};
               3'd4:    sh = {in_byte[3:0], 28'd0};
               3'd5:    sh = {in_byte[3:0], 28'd0};
               3'd6:    sh = {7'd0, in_byte[6:0], 18'd0};
               default: sh = {in_byte[6:0], 25'd0};
            endcase
            acc_in = acc_ff | sh;
            nb_in  = nb_ff + 3'd1;
            if (in_byte[7]) begin
               if (nb_in >= 3'd5) fail = 1'b1;
            end else begin
               v      = acc_in;
               acc_in = '0;
               nb_in  = '0;
               case (phase_ff)
                  PH_TOP_KEY, PH_SUB_KEY: begin
                     fld_in = v[31:3];
                     case (v[2:0])
                        3'd0: phase_in = (phase_ff == PH_SUB_KEY) ? PH_SUB_VAL : PH_TOP_VAL;
                        3'd1: begin skip_in = 32'd8; phase_in = PH_SKIP; end
                        3'd5: begin skip_in = 32'd4; phase_in = PH_SKIP; end
                        3'd2: phase_in = (phase_ff == PH_SUB_KEY) ? PH_SUB_LEN : PH_TOP_LEN;
                        default: fail = 1'b1;
                     endcase
                  end
                  PH_TOP_VAL: begin
                     result.ev.value = v;
                     if (fld_ff == 29'd1) begin
                        result.ev_valid = 1'b1; result.ev.kind = EV_NONCE;
                     end else if (fld_ff == 29'd2) begin
                        result.ev_valid = 1'b1; result.ev.kind = EV_NODE_ID;
                     end else if (fld_ff == 29'd3) begin
                        result.ev_valid = 1'b1; result.ev.kind = EV_ADDRESSED;
                        result.ev.value = {31'd0, v != 32'd0};
                     end
                     phase_in = PH_TOP_KEY;
                  end
                  PH_TOP_LEN: begin
                     if (fld_ff >= 29'd10 && fld_ff <= 29'd17) op_in = 4'(fld_ff - 29'd9);
                     if (fld_ff == 29'd12 || fld_ff == 29'd13 || fld_ff == 29'd14
                         || fld_ff == 29'd16) begin
                        sk_in = (fld_ff == 29'd12) ? SK_REBOOT :
                                (fld_ff == 29'd13) ? SK_BEGIN :
                                (fld_ff == 29'd14) ? SK_CHUNK : SK_NFC;
                        if (v == 32'd0) close = 1'b1;
                        else begin
                           insub_in  = 1'b1;
                           subrem_in = v;
                           phase_in  = PH_SUB_KEY;
                        end
                     end else if (v == 32'd0) phase_in = PH_TOP_KEY;
                     else begin
                        skip_in  = v;
                        phase_in = PH_SKIP;
                     end
                  end
                  PH_SUB_VAL: begin
                     result.ev.value = v;
                     case (sk_ff)
                        SK_REBOOT: begin
                           result.ev.value = {31'd0, v != 32'd0};
                           if (fld_ff == 29'd1) begin
                              result.ev_valid = 1'b1; result.ev.kind = EV_REBOOT_UPD;
                           end else if (fld_ff == 29'd2) begin
                              result.ev_valid = 1'b1; result.ev.kind = EV_REBOOT_ROM;
                           end
                        end
                        SK_BEGIN: begin
                           if (fld_ff >= 29'd1 && fld_ff <= 29'd4) begin
                              result.ev_valid = 1'b1;
                              result.ev.kind  = EV_FLASH_SIZE + 5'(fld_ff) - 5'd1;
                           end else if (fld_ff == 29'd5) begin
                              result.ev_valid = 1'b1; result.ev.kind = EV_UART_INV;
                              result.ev.value = {31'd0, v != 32'd0};
                           end
                        end
                        SK_CHUNK: begin
                           if (fld_ff == 29'd1) begin
                              result.ev_valid = 1'b1; result.ev.kind = EV_CHUNK_OFS;
                           end
                        end
                        SK_NFC: begin
                           if (fld_ff == 29'd1) begin
                              nfc_in = v;
                              result.ev_valid = 1'b1; result.ev.kind = EV_NFC_CMD;
                           end
                        end
                        default: ;
                     endcase
                     phase_in = PH_SUB_KEY;
                  end
                  PH_SUB_LEN: begin
                     data = fld_ff == 29'd2 && (sk_ff == SK_CHUNK || sk_ff == SK_NFC);
                     if (v > subrem_in) fail = 1'b1;
                     else if (data && sk_ff == SK_CHUNK && v > CHUNK_LIM) fail = 1'b1;
                     else if (data && sk_ff == SK_NFC && v > NFC_LIM) fail = 1'b1;
                     else begin
                        if (data) begin
                           result.ev_valid = 1'b1;
                           result.ev.kind  = (sk_ff == SK_CHUNK) ? EV_CHUNK_LEN : EV_NFC_LEN;
                           result.ev.value = v;
                        end
                        if (v == 32'd0) phase_in = PH_SUB_KEY;
                        else begin
                           skip_in  = v;
                           phase_in = data ? PH_SUB_DATA : PH_SKIP;
                        end
                     end
                  end
                  default: fail = 1'b1;
               endcase
            end
         end
         // submessage exhausted after this byte
         if (!fail && !close && insub_in && subrem_in == 32'd0) begin
            if (phase_in == PH_SUB_KEY) close = 1'b1;
            else fail = 1'b1;
         end
         if (close) begin
            if (sk_in == SK_NFC && (nfc_in < nfc_low || nfc_in > nfc_high)) fail = 1'b1;
            else begin
               insub_in = 1'b0;
               sk_in    = SK_NONE;
               phase_in = PH_TOP_KEY;
            end
         end
         if (fail) begin
            err_in   = 1'b1;
            phase_in = PH_ERROR;
         end
      end

      // verdict
      if (msg_last) begin
         ph = phase_in;
         ok = !err_in && ph == PH_TOP_KEY && !insub_in && op_in != 4'd0;
         result.end_valid  = 1'b1;
         result.end_ev     = '0;
         result.end_ev.kind = EV_END;
         result.end_ev.op  = op_in;
         result.end_ev.ok  = ok;
         result.end_ev.eom = 1'b1;
         phase_in  = PH_TOP_KEY;
         insub_in  = 1'b0;
         sk_in     = SK_NONE;
         acc_in    = '0;
         nb_in     = '0;
         fld_in    = '0;
         subrem_in = '0;
         skip_in   = '0;
         op_in     = '0;
         nfc_in    = '0;
         err_in    = 1'b0;
      end
   end

endmodule

/* rtl/pbhcp_outq.sv */
// ----------------------------------------------------------------------------
// pbhcp_outq: result queue
// Four-entry event queue; stalls input when fewer than two slots are free.
// ----------------------------------------------------------------------------
module pbhcp_outq (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pbhcp_pkg::step_out_type  result,
   output logic                     room,
   output logic                     out_valid,
   input  logic                     out_stall,
   output pbhcp_pkg::event_type     out_ev
);
   import pbhcp_pkg::*;

   event_type  mem_ff [4];
   logic [1:0] rd_ff, rd_in;
   logic [1:0] wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;
   logic [1:0] n_push;

   assign out_valid = cnt_ff != 3'd0;
   assign out_ev    = mem_ff[rd_ff];
   assign pop       = out_valid && !out_stall;
   assign room      = cnt_ff <= 3'd2;

   // pointers and count
   always_comb begin
      n_push = '0;
      if (push) n_push = 2'(result.ev_valid) + 2'(result.end_valid);
      wr_in  = wr_ff + n_push;
      rd_in  = rd_ff + 2'(pop);
      cnt_in = cnt_ff + 3'(n_push) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= '0;
         wr_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push && result.ev_valid) mem_ff[wr_ff] <= result.ev;
      if (push && result.end_valid)
         mem_ff[wr_ff + 2'(result.ev_valid)] <= result.end_ev;
   end

endmodule

/* rtl/protobuf_host_command_parser_top.sv */
// ----------------------------------------------------------------------------
// protobuf_host_command_parser_top: streaming host command decoder
//   channel | direction | beat
//   req_    | in        | in_byte, msg_last
//   rsp_    | out       | event_kind, event_value, message_op, message_ok, eom
//   csr_    | in        | index, write data (nfc_cmd_low, nfc_cmd_high)
// One byte beat per cycle unless stalled; state advances in the cycle the beat is taken.
// Results are registered in the result queue before rsp_; a byte yields up to two beats.
// req_stall rises while the four-entry result queue has under two free slots.
// Synchronous reset clears parse state and the queue; csr registers reset too.
// ----------------------------------------------------------------------------
module protobuf_host_command_parser_top #(
   parameter int CHUNK_MAX       = 256,
   parameter int NFC_PAYLOAD_MAX = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        req_msg_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_event_kind,
   output logic [31:0] rsp_event_value,
   output logic [3:0]  rsp_message_op,
   output logic        rsp_message_ok,
   output logic        rsp_end_of_message,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import pbhcp_pkg::*;

   logic [31:0]  low_ff, high_ff;
   logic         room, step;
   step_out_type result;
   event_type    ev;

   assign csr_ready = 1'b1;
   assign req_stall = !room;
   assign step      = req_valid && room;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         high_ff <= '1;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NFC_LOW:  low_ff  <= csr_wdata;
            CSR_NFC_HIGH: high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   pbhcp_core #(.CHUNK_MAX(CHUNK_MAX), .NFC_PAYLOAD_MAX(NFC_PAYLOAD_MAX)) u_core (
      .clock, .reset, .step,
      .in_byte (req_in_byte),
      .msg_last(req_msg_last),
      .nfc_low (low_ff),
      .nfc_high(high_ff),
      .result
   );

   pbhcp_outq u_outq (
      .clock, .reset,
      .push     (step),
      .result,
      .room,
      .out_valid(rsp_valid),
      .out_stall(rsp_stall),
      .out_ev   (ev)
   );

   assign rsp_event_kind     = ev.kind;
   assign rsp_event_value    = ev.value;
   assign rsp_message_op     = ev.op;
   assign rsp_message_ok     = ev.ok;
   assign rsp_end_of_message = ev.eom;

endmodule

/* rtl/pbhcp_checker.sv */
// ----------------------------------------------------------------------------
// pbhcp_checker: port-level checks
// Watches the ports of the top level over time.
// ----------------------------------------------------------------------------
module pbhcp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_msg_last,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [4:0]  rsp_event_kind,
   input logic [31:0] rsp_event_value,
   input logic        rsp_message_ok,
   input logic        rsp_end_of_message
);
   import pbhcp_pkg::*;

   // a stalled result beat stays valid and keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_value))
      else $error("rsp beat changed under stall");

   // end flag goes with end kind
   a_eom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_end_of_message == (rsp_event_kind == EV_END)))
      else $error("end flag and kind disagree");

   // ok only on end beats
   a_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_message_ok |-> rsp_end_of_message)
      else $error("ok outside end beat");

   // a last byte taken produces a result next cycle
   a_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_msg_last |=> rsp_valid)
      else $error("verdict missing");

endmodule

bind protobuf_host_command_parser_top pbhcp_checker u_chk (.*);
